// ===== rtl/alpha_blend_pixel_store_core_macros.svh =====
// Assertion macros used by the pixel store memory engine.
`ifndef ALPHA_BLEND_PIXEL_STORE_CORE_MACROS_SVH
`define ALPHA_BLEND_PIXEL_STORE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ABPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("abps same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define ABPS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("abps next-cycle check failed");

`endif

// ===== rtl/abps_pkg.sv =====
// Shared constants, field layout and types of the alpha blend pixel store.
`default_nettype none

package abps_pkg;

    localparam int MAX_WIDTH   = 512;
    localparam int MAX_HEIGHT  = 512;
    localparam int MEM_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int CNT_W       = ADDR_W + 1;

    localparam int CFG_W       = 10;
    localparam int CFG_RESET   = 512;
    localparam int POS_W       = 9;
    localparam int CHAN_W      = 8;
    localparam int KIND_W      = 2;
    localparam int PROD_W      = 2 * CHAN_W;

    localparam int X_LSB       = 0;
    localparam int Y_LSB       = X_LSB + POS_W;
    localparam int R_LSB       = Y_LSB + POS_W;
    localparam int G_LSB       = R_LSB + CHAN_W;
    localparam int B_LSB       = G_LSB + CHAN_W;
    localparam int A_LSB       = B_LSB + CHAN_W;
    localparam int S_DATA_W    = 56;
    localparam int M_DATA_W    = 3 * CHAN_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CHAN_W-1:0] ALPHA_FULL = {CHAN_W{1'b1}};

    localparam logic CFG_ACTIVE_WIDTH  = 1'b0;
    localparam logic CFG_ACTIVE_HEIGHT = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CLEAR = 2'd2
    } req_kind_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              in_area;
        logic [CHAN_W-1:0] alpha;
        pixel_t            color;
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  count;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        pixel_t color;
        logic   out_of_range;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/abps_front.sv =====
// Request intake: active area registers, range check and address computation.
`default_nettype none

module abps_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic                              cfg_index,
    input  wire logic [abps_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [abps_pkg::S_DATA_W-1:0]     s_tdata,
    input  wire logic [abps_pkg::KIND_W-1:0]       s_tuser,
    input  wire abps_pkg::q_status_t               q_status,
    input  wire logic                              init_done,
    output logic                                   push,
    output abps_pkg::cmd_t                         push_cmd
);

    localparam int MUL_W  = abps_pkg::POS_W + abps_pkg::CFG_W;
    localparam int AREA_W = 2 * abps_pkg::CFG_W;

    logic [abps_pkg::CFG_W-1:0]  width_reg;
    logic [abps_pkg::CFG_W-1:0]  height_reg;
    logic [abps_pkg::CFG_W-1:0]  w_eff;
    logic [abps_pkg::CFG_W-1:0]  h_eff;
    logic [abps_pkg::POS_W-1:0]  pos_x;
    logic [abps_pkg::POS_W-1:0]  pos_y;
    logic [MUL_W-1:0]            addr_full;
    logic [AREA_W-1:0]           area;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= abps_pkg::CFG_W'(abps_pkg::CFG_RESET);
            height_reg <= abps_pkg::CFG_W'(abps_pkg::CFG_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                abps_pkg::CFG_ACTIVE_WIDTH:  width_reg  <= cfg_data;
                abps_pkg::CFG_ACTIVE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        w_eff = (int'(width_reg) > abps_pkg::MAX_WIDTH) ?
                abps_pkg::CFG_W'(abps_pkg::MAX_WIDTH) : width_reg;
        h_eff = (int'(height_reg) > abps_pkg::MAX_HEIGHT) ?
                abps_pkg::CFG_W'(abps_pkg::MAX_HEIGHT) : height_reg;
        pos_x = s_tdata[abps_pkg::X_LSB +: abps_pkg::POS_W];
        pos_y = s_tdata[abps_pkg::Y_LSB +: abps_pkg::POS_W];
        addr_full = MUL_W'(pos_y) * MUL_W'(w_eff) + MUL_W'(pos_x);
        area      = AREA_W'(w_eff) * AREA_W'(h_eff);

        push_cmd.kind        = s_tuser;
        push_cmd.in_area     = (abps_pkg::CFG_W'(pos_x) < w_eff) &&
                               (abps_pkg::CFG_W'(pos_y) < h_eff);
        push_cmd.alpha       = s_tdata[abps_pkg::A_LSB +: abps_pkg::CHAN_W];
        push_cmd.color.red   = s_tdata[abps_pkg::R_LSB +: abps_pkg::CHAN_W];
        push_cmd.color.green = s_tdata[abps_pkg::G_LSB +: abps_pkg::CHAN_W];
        push_cmd.color.blue  = s_tdata[abps_pkg::B_LSB +: abps_pkg::CHAN_W];
        push_cmd.addr        = addr_full[abps_pkg::ADDR_W-1:0];
        push_cmd.count       = area[abps_pkg::CNT_W-1:0];
    end

    assign s_tready = !q_status.full && init_done;
    assign push     = s_tvalid && s_tready;

endmodule

`default_nettype wire

// ===== rtl/abps_queue.sv =====
// Short request queue between intake and the pixel memory engine.
`default_nettype none

module abps_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire abps_pkg::cmd_t    push_cmd,
    input  wire logic              pop,
    output abps_pkg::cmd_t         head,
    output abps_pkg::q_status_t    status
);

    abps_pkg::cmd_t                 slot_reg [abps_pkg::QUEUE_DEPTH];
    logic [abps_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [abps_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [abps_pkg::QPTR_W:0]      count_reg;
    logic [abps_pkg::QPTR_W:0]      count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    assign head         = slot_reg[rd_ptr_reg];
    assign status.full  = (count_reg == (abps_pkg::QPTR_W + 1)'(abps_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

`default_nettype wire

// ===== rtl/abps_back.sv =====
// Pixel memory engine: clearing pass, blend read-modify-write, fill and result register.
`default_nettype none

`include "alpha_blend_pixel_store_core_macros.svh"

module abps_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire abps_pkg::cmd_t    q_head,
    input  wire logic              q_empty,
    output logic                   q_pop,
    output logic                   init_done,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output abps_pkg::result_t      m_result
);

    localparam int CW = abps_pkg::CHAN_W;
    localparam int PW = abps_pkg::PROD_W;

    typedef enum logic [5:0] {
        ST_INIT = 6'b000001,
        ST_IDLE = 6'b000010,
        ST_READ = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_FILL = 6'b010000,
        ST_DONE = 6'b100000
    } back_state_t;

    back_state_t                    state_reg, state_next;
    logic [abps_pkg::ADDR_W-1:0]    sweep_reg, sweep_next;
    abps_pkg::cmd_t                 cur_reg, cur_next;
    abps_pkg::result_t              res_reg, res_next;
    logic                           out_valid_reg;
    abps_pkg::result_t              out_reg;
    logic                           out_load;

    logic [23:0]                    mem [abps_pkg::MEM_DEPTH];
    abps_pkg::pixel_t               rd_data_reg;
    logic                           rd_en;
    logic [abps_pkg::ADDR_W-1:0]    rd_addr;
    logic                           wr_en;
    logic [abps_pkg::ADDR_W-1:0]    wr_addr;
    abps_pkg::pixel_t               wr_data;

    logic [CW-1:0]                  dst_ch [3];
    logic [CW-1:0]                  src_ch [3];
    logic [CW-1:0]                  inv_alpha;
    logic [PW-1:0]                  pd_reg [3];
    logic [PW-1:0]                  ps_reg [3];
    logic [CW-1:0]                  mix_ch [3];
    abps_pkg::pixel_t               mix_pix;

    function automatic logic [CW-1:0] div255(input logic [PW:0] v);
        logic [PW:0] t;
        t = v + (v >> CW) + (PW + 1)'(1);
        return t[PW-1:CW];
    endfunction

    always_comb
    begin
        dst_ch[0] = rd_data_reg.red;
        dst_ch[1] = rd_data_reg.green;
        dst_ch[2] = rd_data_reg.blue;
        src_ch[0] = cur_reg.color.red;
        src_ch[1] = cur_reg.color.green;
        src_ch[2] = cur_reg.color.blue;
        inv_alpha = abps_pkg::ALPHA_FULL - cur_reg.alpha;
        for (int c = 0; c < 3; c++)
        begin
            mix_ch[c] = div255((PW + 1)'(pd_reg[c]) + (PW + 1)'(ps_reg[c]) +
                               (PW + 1)'(127));
        end
        mix_pix.red   = mix_ch[0];
        mix_pix.green = mix_ch[1];
        mix_pix.blue  = mix_ch[2];
    end

    always_comb
    begin
        state_next = state_reg;
        sweep_next = sweep_reg;
        cur_next   = cur_reg;
        res_next   = res_reg;
        q_pop      = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = q_head.addr;
        wr_en      = 1'b0;
        wr_addr    = sweep_reg;
        wr_data    = '0;
        out_load   = 1'b0;

        case (state_reg)
            ST_INIT:
            begin
                wr_en = 1'b1;
                if (sweep_reg == abps_pkg::ADDR_W'(abps_pkg::MEM_DEPTH - 1))
                begin
                    sweep_next = '0;
                    state_next = ST_IDLE;
                end
                else
                    sweep_next = sweep_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    cur_next   = q_head;
                    res_next   = '0;
                    state_next = ST_DONE;
                    case (abps_pkg::req_kind_t'(q_head.kind))
                        abps_pkg::REQ_WRITE:
                        begin
                            if (!q_head.in_area)
                                res_next.out_of_range = 1'b1;
                            else if (q_head.alpha == abps_pkg::ALPHA_FULL)
                            begin
                                wr_en   = 1'b1;
                                wr_addr = q_head.addr;
                                wr_data = q_head.color;
                            end
                            else if (q_head.alpha != '0)
                            begin
                                rd_en      = 1'b1;
                                state_next = ST_READ;
                            end
                        end
                        abps_pkg::REQ_READ:
                        begin
                            if (q_head.in_area)
                            begin
                                rd_en      = 1'b1;
                                state_next = ST_READ;
                            end
                            else
                                res_next.out_of_range = 1'b1;
                        end
                        abps_pkg::REQ_CLEAR:
                        begin
                            sweep_next = '0;
                            if (q_head.count != '0)
                                state_next = ST_FILL;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ:
            begin
                if (cur_reg.kind == abps_pkg::REQ_READ)
                begin
                    res_next.color = rd_data_reg;
                    state_next     = ST_DONE;
                end
                else
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                wr_en      = 1'b1;
                wr_addr    = cur_reg.addr;
                wr_data    = mix_pix;
                state_next = ST_DONE;
            end
            ST_FILL:
            begin
                wr_en   = 1'b1;
                wr_data = cur_reg.color;
                if (abps_pkg::CNT_W'(sweep_reg) + 1'b1 == cur_reg.count)
                    state_next = ST_DONE;
                else
                    sweep_next = sweep_reg + 1'b1;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_INIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        res_reg <= res_next;
        if (out_load)
            out_reg <= res_reg;
        if (state_reg == ST_READ)
        begin
            for (int c = 0; c < 3; c++)
            begin
                pd_reg[c] <= PW'(dst_ch[c]) * PW'(inv_alpha);
                ps_reg[c] <= PW'(src_ch[c]) * PW'(cur_reg.alpha);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign init_done = (state_reg != ST_INIT);
    assign m_tvalid  = out_valid_reg;
    assign m_result  = out_reg;

    `ABPS_ASSERT_IMP(a_init_quiet, clk, rst_n, state_reg == ST_INIT, !out_valid_reg)
    `ABPS_ASSERT_IMP(a_fill_clear, clk, rst_n, state_reg == ST_FILL, cur_reg.kind == abps_pkg::REQ_CLEAR)
    `ABPS_ASSERT_NXT(a_done_load, clk, rst_n, out_load, out_valid_reg && state_reg == ST_IDLE)
    `ABPS_ASSERT_IMP(a_pop_idle, clk, rst_n, q_pop, !q_empty && state_reg == ST_IDLE)

endmodule

`default_nettype wire

// ===== rtl/alpha_blend_pixel_store_core.sv =====
// Top level of the alpha blend pixel store: intake, request queue and memory engine.
// Path from request to result valid: plain writes and out-of-range requests pass IDLE and
// DONE, reads add READ, partial-alpha blends add READ and DIV, and a clear adds FILL.
// Throughput is set by the pixel memory engine, which takes a new request from the queue
// only once the last result is loaded, and a clear holds it until width*height pixels are filled.
// Reset runs a clearing pass over all MAX_WIDTH*MAX_HEIGHT (262144) pixels with s_tready low.
`default_nettype none

module alpha_blend_pixel_store_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic                              cfg_index,
    input  wire logic [abps_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // pos_x[8:0], pos_y[17:9], src_red[25:18], src_green[33:26], src_blue[41:34],
    // src_alpha[49:42], zero pad[55:50]
    input  wire logic [abps_pkg::S_DATA_W-1:0]     s_tdata,
    // req_type[1:0]
    input  wire logic [abps_pkg::KIND_W-1:0]       s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // out_red[7:0], out_green[15:8], out_blue[23:16]
    output logic [abps_pkg::M_DATA_W-1:0]          m_tdata,
    // out_of_range[0]
    output logic                                   m_tuser
);

    abps_pkg::q_status_t   q_status;
    abps_pkg::cmd_t        push_cmd;
    abps_pkg::cmd_t        q_head;
    abps_pkg::result_t     result;
    logic                  push;
    logic                  q_pop;
    logic                  init_done;

    abps_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_status  (q_status),
        .init_done (init_done),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    abps_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .status   (q_status)
    );

    abps_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_head    (q_head),
        .q_empty   (q_status.empty),
        .q_pop     (q_pop),
        .init_done (init_done),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_result  (result)
    );

    assign m_tdata = {result.color.blue, result.color.green, result.color.red};
    assign m_tuser = result.out_of_range;

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Testbench for the alpha blend pixel store: blends, reads, clears and resizes vs a shadow buffer.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import abps_pkg::*;

    localparam logic [KIND_W-1:0] REQ_UNUSED = 2'd3;
    localparam int     CLK_HALF       = 10;
    localparam int     RESET_CYCLES   = 5;
    localparam longint CYCLE_LIMIT    = 3_000_000;
    localparam int     SETTLE_CYCLES  = 8;
    localparam int     TAIL_CYCLES    = 40;
    localparam int     CLEAR_AREA_CAP = 4096;
    localparam int     POS_MAX        = (1 << POS_W) - 1;
    localparam int     PRINT_CAP      = 40;
    localparam int     HOLD_CYCLES    = 400;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic                cfg_index = 1'b0;
    logic [CFG_W-1:0]    cfg_data  = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic [KIND_W-1:0]   s_tuser   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;

    // shadow framebuffer: red in 23:16, green in 15:8, blue in 7:0
    logic [M_DATA_W-1:0] frame_mem [MEM_DEPTH];
    logic [CFG_W-1:0]    cols_reg = CFG_W'(CFG_RESET);
    logic [CFG_W-1:0]    rows_reg = CFG_W'(CFG_RESET);
    result_t             pixel_replies [$];
    int unsigned         recent_x [$];
    int unsigned         recent_y [$];

    int     error_count   = 0;
    int     n_requests    = 0;
    int     n_writes      = 0;
    int     n_reads       = 0;
    int     n_clears      = 0;
    int     n_out_range   = 0;
    int     n_resizes     = 0;
    longint cycle_count   = 0;
    int     sink_hold_req = 0;
    bit     src_steady    = 1'b0;
    bit     sink_steady   = 1'b0;

    alpha_blend_pixel_store_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL alpha_blend_pixel_store_core");
            $finish;
        end
    end

    function automatic int unsigned active_cols();
        return (cols_reg > MAX_WIDTH) ? MAX_WIDTH : cols_reg;
    endfunction

    function automatic int unsigned active_rows();
        return (rows_reg > MAX_HEIGHT) ? MAX_HEIGHT : rows_reg;
    endfunction

    function automatic logic [CHAN_W-1:0] blend_channel(input int unsigned dst,
                                                        input int unsigned src,
                                                        input int unsigned a);
        int unsigned mixed;
        mixed = (dst * (255 - a) + src * a + 127) / 255;
        return CHAN_W'(mixed);
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(3, 1);
        if (roll < 97)
            return $urandom_range(12, 4);
        return $urandom_range(90, 20);
    endfunction

    // Apply one request to the shadow framebuffer and queue the reply it should produce.
    function automatic void predict_reply(logic [KIND_W-1:0] kind, int unsigned x, int unsigned y,
                                          logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                          logic [CHAN_W-1:0] b, logic [CHAN_W-1:0] a);
        int unsigned         w;
        int unsigned         h;
        int unsigned         addr;
        bit                  in_area;
        logic [M_DATA_W-1:0] old;
        result_t             reply;
        w       = active_cols();
        h       = active_rows();
        in_area = (x < w) && (y < h);
        addr    = in_area ? x + y * w : 0;
        reply   = '0;
        n_requests++;
        case (kind)
            REQ_WRITE:
            begin
                n_writes++;
                if (!in_area)
                    reply.out_of_range = 1'b1;
                else if (a == ALPHA_FULL)
                    frame_mem[addr] = {r, g, b};
                else if (a != '0)
                begin
                    old = frame_mem[addr];
                    frame_mem[addr] = {blend_channel(old[23:16], r, a),
                                       blend_channel(old[15:8], g, a),
                                       blend_channel(old[7:0], b, a)};
                end
            end
            REQ_READ:
            begin
                n_reads++;
                if (in_area)
                begin
                    reply.color.red   = frame_mem[addr][23:16];
                    reply.color.green = frame_mem[addr][15:8];
                    reply.color.blue  = frame_mem[addr][7:0];
                end
                else
                    reply.out_of_range = 1'b1;
            end
            REQ_CLEAR:
            begin
                n_clears++;
                for (int unsigned i = 0; i < w * h; i++)
                    frame_mem[i] = {r, g, b};
            end
            default: ;
        endcase
        if (reply.out_of_range)
            n_out_range++;
        pixel_replies.push_back(reply);
    endfunction

    task automatic report_mismatch(string what, int unsigned got_v, int unsigned want_v);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("[%0t] mismatch: %s got %0h expected %0h", $time, what, got_v, want_v);
    endtask

    always @(posedge clk)
    begin : bus_watch
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.color.red    = m_tdata[0 +: CHAN_W];
                got.color.green  = m_tdata[CHAN_W +: CHAN_W];
                got.color.blue   = m_tdata[2*CHAN_W +: CHAN_W];
                got.out_of_range = m_tuser;
                if (pixel_replies.size() == 0)
                    report_mismatch("reply with no request pending", 1, 0);
                else
                begin
                    want = pixel_replies.pop_front();
                    if (got.color.red !== want.color.red)
                        report_mismatch("out_red", got.color.red, want.color.red);
                    if (got.color.green !== want.color.green)
                        report_mismatch("out_green", got.color.green, want.color.green);
                    if (got.color.blue !== want.color.blue)
                        report_mismatch("out_blue", got.color.blue, want.color.blue);
                    if (got.out_of_range !== want.out_of_range)
                        report_mismatch("out_of_range", got.out_of_range, want.out_of_range);
                end
            end
            if (cfg_we)
            begin
                n_resizes++;
                if (cfg_index == CFG_ACTIVE_WIDTH)
                    cols_reg = cfg_data;
                else
                    rows_reg = cfg_data;
            end
            if (s_tvalid && s_tready)
                predict_reply(s_tuser, s_tdata[X_LSB +: POS_W], s_tdata[Y_LSB +: POS_W],
                              s_tdata[R_LSB +: CHAN_W], s_tdata[G_LSB +: CHAN_W],
                              s_tdata[B_LSB +: CHAN_W], s_tdata[A_LSB +: CHAN_W]);
        end
    end

    initial
    begin : reply_sink
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (sink_hold_req > 0)
            begin
                stall_left    = sink_hold_req;
                sink_hold_req = 0;
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (sink_steady || $urandom_range(99) < 70)
                m_tready <= 1'b1;
            else
            begin
                stall_left = pick_gap();
                m_tready <= (stall_left == 0);
            end
        end
    end

    // Enter and leave at a falling edge.
    task automatic send_request(logic [KIND_W-1:0] kind, int unsigned x, int unsigned y,
                                logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                logic [CHAN_W-1:0] b, logic [CHAN_W-1:0] a);
        logic [S_DATA_W-1:0] word;
        int                  gap;
        word                     = '0;
        word[X_LSB +: POS_W]     = POS_W'(x);
        word[Y_LSB +: POS_W]     = POS_W'(y);
        word[R_LSB +: CHAN_W]    = r;
        word[G_LSB +: CHAN_W]    = g;
        word[B_LSB +: CHAN_W]    = b;
        word[A_LSB +: CHAN_W]    = a;
        gap = src_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic wait_for_replies();
        s_tvalid <= 1'b0;
        while (pixel_replies.size() != 0)
            @(negedge clk);
    endtask

    task automatic resize_area(int unsigned w, int unsigned h);
        wait_for_replies();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ACTIVE_WIDTH;
        cfg_data  <= CFG_W'(w);
        @(negedge clk);
        cfg_index <= CFG_ACTIVE_HEIGHT;
        cfg_data  <= CFG_W'(h);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_random_request();
        int unsigned       w;
        int unsigned       h;
        int unsigned       x;
        int unsigned       y;
        int unsigned       roll;
        int unsigned       pick;
        logic [KIND_W-1:0] kind;
        logic [CHAN_W-1:0] a;
        w    = active_cols();
        h    = active_rows();
        roll = $urandom_range(99);
        if (roll < 48)
            kind = REQ_WRITE;
        else if (roll < 92)
            kind = REQ_READ;
        else if (roll < 97)
            kind = (w * h <= CLEAR_AREA_CAP) ? REQ_CLEAR : REQ_READ;
        else
            kind = REQ_UNUSED;
        roll = $urandom_range(99);
        if (kind == REQ_READ && recent_x.size() > 0 && roll < 50)
        begin
            pick = $urandom_range(recent_x.size() - 1);
            x    = recent_x[pick];
            y    = recent_y[pick];
        end
        else if (w > 0 && h > 0 && roll < 60)
        begin
            x = $urandom_range(w - 1);
            y = $urandom_range(h - 1);
        end
        else if (w > 0 && h > 0 && roll < 75)
        begin
            // straddle the active edge
            x = (w - 1 + $urandom_range(1) > POS_MAX) ? POS_MAX : w - 1 + $urandom_range(1);
            y = (h - 1 + $urandom_range(1) > POS_MAX) ? POS_MAX : h - 1 + $urandom_range(1);
        end
        else
        begin
            x = $urandom_range(POS_MAX);
            y = $urandom_range(POS_MAX);
        end
        roll = $urandom_range(99);
        if (roll < 25)
            a = ALPHA_FULL;
        else if (roll < 37)
            a = '0;
        else
            a = CHAN_W'($urandom_range(254, 1));
        if (kind == REQ_WRITE)
        begin
            recent_x.push_back(x);
            recent_y.push_back(y);
            if (recent_x.size() > 16)
            begin
                void'(recent_x.pop_front());
                void'(recent_y.pop_front());
            end
        end
        send_request(kind, x, y, CHAN_W'($urandom_range(255)), CHAN_W'($urandom_range(255)),
                     CHAN_W'($urandom_range(255)), a);
    endtask

    task automatic test_power_on_contents();
        send_request(REQ_READ, 0, 0, 8'hff, 8'hff, 8'hff, 8'hff);
        send_request(REQ_READ, POS_MAX, POS_MAX, 8'h00, 8'h00, 8'h00, 8'h00);
    endtask

    task automatic test_blend_modes();
        send_request(REQ_WRITE, POS_MAX, POS_MAX, 8'hff, 8'hff, 8'hff, ALPHA_FULL);
        send_request(REQ_READ, POS_MAX, POS_MAX, 8'h00, 8'h00, 8'h00, 8'h00);
        send_request(REQ_WRITE, POS_MAX, POS_MAX, 8'h00, 8'h00, 8'h00, 8'h00);
        send_request(REQ_WRITE, POS_MAX, POS_MAX, 8'h00, 8'h80, 8'hff, 8'h80);
        send_request(REQ_READ, POS_MAX, POS_MAX, 8'h00, 8'h00, 8'h00, 8'h00);
        send_request(REQ_WRITE, 0, 0, 8'hff, 8'hff, 8'hff, 8'h01);
        send_request(REQ_WRITE, 0, 0, 8'h10, 8'h20, 8'h30, 8'hfe);
        send_request(REQ_READ, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00);
        send_request(REQ_WRITE, 0, POS_MAX, 8'hc3, 8'h3c, 8'h81, ALPHA_FULL);
        send_request(REQ_READ, 0, POS_MAX, 8'h00, 8'h00, 8'h00, 8'h00);
    endtask

    task automatic test_clear_and_unused();
        send_request(REQ_UNUSED, POS_MAX, POS_MAX, 8'hff, 8'hff, 8'hff, ALPHA_FULL);
        send_request(REQ_READ, POS_MAX, POS_MAX, 8'h00, 8'h00, 8'h00, 8'h00);
        // full-area clear, alpha and position must not matter
        send_request(REQ_CLEAR, 123, 456, 8'h5a, 8'ha5, 8'h3c, 8'h00);
        send_request(REQ_READ, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00);
        send_request(REQ_READ, POS_MAX, POS_MAX, 8'h00, 8'h00, 8'h00, 8'h00);
    endtask

    task automatic test_resize_edges();
        resize_area(0, 0);
        send_request(REQ_WRITE, 0, 0, 8'h11, 8'h22, 8'h33, ALPHA_FULL);
        send_request(REQ_READ, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00);
        send_request(REQ_CLEAR, 0, 0, 8'h77, 8'h77, 8'h77, ALPHA_FULL);
        resize_area((1 << CFG_W) - 1, (1 << CFG_W) - 1);
        send_request(REQ_READ, POS_MAX, POS_MAX, 8'h00, 8'h00, 8'h00, 8'h00);
        resize_area(3, 2);
        send_request(REQ_WRITE, 3, 0, 8'h01, 8'h02, 8'h03, ALPHA_FULL);
        send_request(REQ_WRITE, 0, 2, 8'h01, 8'h02, 8'h03, ALPHA_FULL);
        send_request(REQ_WRITE, 2, 1, 8'he1, 8'hd2, 8'hc3, ALPHA_FULL);
        send_request(REQ_READ, 2, 1, 8'h00, 8'h00, 8'h00, 8'h00);
        resize_area(MAX_WIDTH, MAX_HEIGHT);
        send_request(REQ_READ, 5, 0, 8'h00, 8'h00, 8'h00, 8'h00);
    endtask

    task automatic test_random_phases();
        int unsigned cols_list [12] = '{512, 1, 0, 5, 1023, 7, 64, 512, 1, 300, 1023, 0};
        int unsigned rows_list [12] = '{512, 1, 5, 0, 3, 9, 32, 1, 512, 13, 1023, 0};
        for (int p = 0; p < 12; p++)
        begin
            if (p == 11)
            begin
                cols_list[p] = $urandom_range(40, 1);
                rows_list[p] = $urandom_range(40, 1);
            end
            resize_area(cols_list[p], rows_list[p]);
            src_steady  = ($urandom_range(3) == 0);
            sink_steady = ($urandom_range(3) == 0);
            repeat (40) send_random_request();
        end
        src_steady  = 1'b0;
        sink_steady = 1'b0;
    endtask

    task automatic test_backpressure();
        resize_area(64, 64);
        sink_hold_req = HOLD_CYCLES;
        src_steady    = 1'b1;
        repeat (30) send_random_request();
        // hold the source until every reply is back
        wait_for_replies();
        repeat (10) send_random_request();
        src_steady = 1'b0;
    endtask

    initial
    begin : run_tests
        foreach (frame_mem[i])
            frame_mem[i] = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_power_on_contents();
        test_blend_modes();
        test_clear_and_unused();
        test_resize_edges();
        test_random_phases();
        test_backpressure();
        wait_for_replies();
        repeat (TAIL_CYCLES) @(negedge clk);
        $display("Covered %0d requests: %0d writes, %0d reads, %0d clears, %0d out of range.",
                 n_requests, n_writes, n_reads, n_clears, n_out_range);
        $display("Area resized through %0d register writes, including zero and saturated sizes.",
                 n_resizes);
        if (error_count == 0 && pixel_replies.size() == 0)
            $display("PASS alpha_blend_pixel_store_core");
        else
            $display("FAIL alpha_blend_pixel_store_core");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/abps_pkg.sv
rtl/abps_front.sv
rtl/abps_queue.sv
rtl/abps_back.sv
rtl/alpha_blend_pixel_store_core.sv
tb/sv/testbench.sv
